FILE: sv/isic_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isic_pkg
// Shared constants and types for the insertion sort inversion counter.
// ---------------------------------------------------------------------------
package isic_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int INV_W    = 11;
    localparam int TDATA_W  = 48;

    // popcount of the comparison vector in groups of eight
    localparam int CNT_GRP  = 8;
    localparam int NGRP     = (CAPACITY + CNT_GRP - 1) / CNT_GRP;
    localparam int PAD_W    = NGRP * CNT_GRP;
    localparam int GRP_W    = $clog2(CNT_GRP + 1);
    localparam int SUM_W    = $clog2(CAPACITY + 1);

    localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] val;
    } cell_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_EMIT
    } state_t;

endpackage : isic_pkg
`default_nettype wire

FILE: sv/isic_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isic_cell
// One slot of the sorting chain: compares the incoming sample with its own
// value, shifts up on insert and down on pop.
// ---------------------------------------------------------------------------
module isic_cell
    import isic_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  cell_ctrl_t        ctrl,
    input  wire  [DATA_W-1:0] din,
    input  cell_t             left,
    input  wire               left_below,
    input  cell_t             right,
    output cell_t             q,
    output logic              below,
    output logic              gt
);

    logic              vld_reg, vld_next;
    logic [DATA_W-1:0] val_reg, val_next;

    always_comb
    begin
        gt    = vld_reg && ($signed(val_reg) > $signed(din));
        below = vld_reg && !gt;
        q     = '{vld: vld_reg, val: val_reg};
    end

    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (ctrl.pop)
        begin
            vld_next = right.vld;
            val_next = right.val;
        end
        else if (ctrl.ins && !below)
        begin
            vld_next = 1'b1;
            // equal values stay below, so the new one lands after them
            val_next = left_below ? din : left.val;
            if (!left.vld)
            begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule : isic_cell
`default_nettype wire

FILE: sv/isic_count.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isic_count
// Pipelined popcount of the cell comparison flags and the running,
// saturating inversion total.
// ---------------------------------------------------------------------------
module isic_count
    import isic_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire [CAPACITY-1:0] gt,
    input  wire                gt_en,
    input  wire                clr,
    output logic [INV_W-1:0]   inversions,
    output logic               busy
);

    logic [PAD_W-1:0] gt_pad;
    logic [GRP_W-1:0] grp_cnt_reg  [NGRP];
    logic [GRP_W-1:0] grp_cnt_next [NGRP];
    logic             grp_vld_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             sum_vld_reg;
    logic [INV_W-1:0] inv_reg, inv_next;
    logic [INV_W:0]   inv_wide;

    assign gt_pad = PAD_W'(gt);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_cnt_next[g] = '0;
            for (int b = 0; b < CNT_GRP; b++)
            begin
                grp_cnt_next[g] = grp_cnt_next[g] + GRP_W'(gt_pad[g*CNT_GRP + b]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum_next = sum_next + SUM_W'(grp_cnt_reg[g]);
        end
    end

    always_comb
    begin
        inv_wide = {1'b0, inv_reg} + (INV_W+1)'(sum_reg);
        inv_next = inv_reg;
        if (clr)
        begin
            inv_next = '0;
        end
        else if (sum_vld_reg)
        begin
            inv_next = inv_wide[INV_W] ? INV_MAX : inv_wide[INV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            inv_reg     <= '0;
        end
        else
        begin
            grp_vld_reg <= gt_en;
            sum_vld_reg <= grp_vld_reg;
            inv_reg     <= inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gt_en)
        begin
            grp_cnt_reg <= grp_cnt_next;
        end
        sum_reg <= sum_next;
    end

    assign inversions = inv_reg;
    assign busy       = grp_vld_reg | sum_vld_reg;

endmodule : isic_count
`default_nettype wire

FILE: sv/insertion_sort_inversion_count.sv
`default_nettype none
// ---------------------------------------------------------------------------
// insertion_sort_inversion_count
// Sorts a run of signed samples in a chain of cells and counts inversions.
// ---------------------------------------------------------------------------
// Slave stream: one signed 32-bit sample per request, tlast on the final one.
// While loading, a sample is taken every cycle: all cells compare against it
// in parallel and the larger ones move up one place, equal values stay put.
// Samples arriving with the chain full are dropped and the overflow flag set.
// After the final request the popcount pipeline drains in ST_FLUSH, then the
// chain shifts out through cell 0, one ascending value per cycle while
// m_tready is high, each with the run's inversion count in tdata and the
// overflow flag in tuser; tlast marks the last value. Cell 0 is the output
// register: a stall on m_tready simply holds the chain. No sample is taken
// after the final request until the last result has been accepted; then
// all run state is clear again. Reset empties the chain and clears count
// and flag.
// ---------------------------------------------------------------------------
module insertion_sort_inversion_count
    import isic_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [DATA_W-1:0]  s_tdata,   // [31:0] sample
    input  wire                s_tlast,   // final_item
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] sorted_value, [42:32] inversions
    output logic               m_tuser,   // overflowed
    output logic               m_tlast    // run_end
);

    state_t        state_reg, state_next;
    logic          ovf_reg, ovf_next;
    cell_ctrl_t    ctrl;
    cell_t         cells [CAPACITY];
    logic          below [CAPACITY];
    logic [CAPACITY-1:0] gt;
    logic          s_acc, m_acc, full, done;
    logic [INV_W-1:0] inversions;
    logic          cnt_busy;

    assign full  = cells[CAPACITY-1].vld;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign done  = m_acc && m_tlast;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_t left_c, right_c;
            logic  left_b;
            if (i == 0)
            begin : g_first
                assign left_c = '{vld: 1'b1, val: '0};
                assign left_b = 1'b1;
            end
            else
            begin : g_mid
                assign left_c = cells[i-1];
                assign left_b = below[i-1];
            end
            if (i == CAPACITY-1)
            begin : g_last
                assign right_c = '{vld: 1'b0, val: '0};
            end
            else
            begin : g_next
                assign right_c = cells[i+1];
            end
            isic_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .din        (s_tdata),
                .left       (left_c),
                .left_below (left_b),
                .right      (right_c),
                .q          (cells[i]),
                .below      (below[i]),
                .gt         (gt[i])
            );
        end
    endgenerate

    isic_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .gt         (gt),
        .gt_en      (ctrl.ins),
        .clr        (done),
        .inversions (inversions),
        .busy       (cnt_busy)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc && s_tlast)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!cnt_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_LOAD:  s_tready = 1'b1;
            ST_FLUSH: s_tready = 1'b0;
            ST_EMIT:  m_tvalid = cells[0].vld;
            default:  s_tready = 1'b0;
        endcase
        ctrl.ins = s_acc && !full;
        ctrl.pop = m_acc;
        m_tdata  = TDATA_W'({inversions, cells[0].val});
        m_tuser  = ovf_reg;
        m_tlast  = !cells[1].vld;
    end

    always_comb
    begin
        ovf_next = ovf_reg;
        if (done)
        begin
            ovf_next = 1'b0;
        end
        else if (s_acc && full)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule : insertion_sort_inversion_count
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stream test of the insertion sort inversion counter. Runs of signed samples
// go in with tlast on the final one. A local copy of the sorting chain works
// out the ascending run, the inversion count and the overflow flag, but
// single-value runs carry their results in the rows. Every result is checked
// field by field, in order. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module tb;
    import isic_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [INV_W-1:0]         inv;
        logic                     ovf;
        logic                     last;
    } sort_out_t;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              fin;
        logic              typed;   // single-value run, result written in the row
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    wire                s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic               s_tlast = 1'b0;
    wire                m_tvalid;
    logic               m_tready = 1'b0;
    wire  [TDATA_W-1:0] m_tdata;
    wire                m_tuser;
    wire                m_tlast;

    // local copy of the chain
    logic signed [DATA_W-1:0] chain [CAPACITY];
    int                       held = 0;
    logic [INV_W-1:0]         inv_total = '0;
    logic                     ovf_seen = 1'b0;

    sort_out_t  sorted_due [$];
    stim_row_t  dir_rows [$];
    int         error_count = 0;
    int         hold_left = 0;
    int         rand_items;
    int         run_len;
    logic       calm = 1'b0;
    logic [DATA_W-1:0] v;

    insertion_sort_inversion_count dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("[insertion_sort_inversion_count] ERROR");
        $finish;
    end

    // Insert one sample after any equal ones, count larger values passed over,
    // and on the final request queue the whole ascending run.
    function automatic void insert_sample(input logic signed [DATA_W-1:0] x,
                                          input logic fin);
        int        pos;
        int        moved;
        int        sum;
        sort_out_t r;
        if (held < CAPACITY)
        begin
            pos   = held;
            moved = 0;
            while (pos > 0 && chain[pos-1] > x)
            begin
                chain[pos] = chain[pos-1];
                pos--;
                moved++;
            end
            chain[pos] = x;
            held++;
            sum = int'(inv_total) + moved;
            inv_total = (sum > int'(INV_MAX)) ? INV_MAX : sum[INV_W-1:0];
        end
        else
        begin
            ovf_seen = 1'b1;
        end
        if (fin)
        begin
            for (int k = 0; k < held; k++)
            begin
                r.value = chain[k];
                r.inv   = inv_total;
                r.ovf   = ovf_seen;
                r.last  = (k == held - 1);
                sorted_due.push_back(r);
            end
            held      = 0;
            inv_total = '0;
            ovf_seen  = 1'b0;
        end
    endfunction

    function automatic stim_row_t row(input logic [DATA_W-1:0] x, input logic fin,
                                      input logic typed);
        stim_row_t r;
        r.sample = x;
        r.fin    = fin;
        r.typed  = typed;
        return r;
    endfunction

    function automatic void note_error(input string msg);
        if (error_count < 10)
            $display("mismatch: %s", msg);
        error_count++;
    endfunction

    // returns at the edge where the request is taken
    task automatic send_sample(input logic [DATA_W-1:0] x, input logic fin);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained;
        while (sorted_due.size() != 0) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_sample;
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return $urandom_range(0, 8) - 4;   // many equal values
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // sink side: random stall bursts, checks every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_due.size() == 0)
            begin
                note_error($sformatf("unexpected result value=%0d inv=%0d ovf=%0b last=%0b",
                                     $signed(m_tdata[31:0]), m_tdata[42:32], m_tuser, m_tlast));
            end
            else
            begin
                if (m_tdata[31:0] !== sorted_due[0].value || m_tdata[42:32] !== sorted_due[0].inv
                    || m_tuser !== sorted_due[0].ovf || m_tlast !== sorted_due[0].last)
                    note_error($sformatf({"expected value=%0d inv=%0d ovf=%0b last=%0b, ",
                                          "got value=%0d inv=%0d ovf=%0b last=%0b"},
                                         sorted_due[0].value, sorted_due[0].inv,
                                         sorted_due[0].ovf, sorted_due[0].last,
                                         $signed(m_tdata[31:0]), m_tdata[42:32],
                                         m_tuser, m_tlast));
                void'(sorted_due.pop_front());
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 6);
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        // single-value runs at the extremes, then short runs for the predictor
        dir_rows.push_back(row(32'h7FFF_FFFF, 1'b1, 1'b1));
        dir_rows.push_back(row(32'h8000_0000, 1'b1, 1'b1));
        dir_rows.push_back(row(32'h0000_0000, 1'b1, 1'b1));
        dir_rows.push_back(row(32'hFFFF_FFFF, 1'b1, 1'b1));
        dir_rows.push_back(row(32'd5,         1'b0, 1'b0));
        dir_rows.push_back(row(32'hFFFF_FFFD, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd5,         1'b0, 1'b0));
        dir_rows.push_back(row(32'h8000_0000, 1'b0, 1'b0));
        dir_rows.push_back(row(32'h7FFF_FFFF, 1'b1, 1'b0));
        dir_rows.push_back(row(32'd3, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd2, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd1, 1'b1, 1'b0));
        dir_rows.push_back(row(32'd1, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd2, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd3, 1'b1, 1'b0));
        dir_rows.push_back(row(32'd7, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd7, 1'b0, 1'b0));
        dir_rows.push_back(row(32'd7, 1'b1, 1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_sample(dir_rows[i].sample, dir_rows[i].fin);
            if (dir_rows[i].typed)
                sorted_due.push_back('{value: dir_rows[i].sample, inv: '0,
                                       ovf: 1'b0, last: 1'b1});
            else
                insert_sample(dir_rows[i].sample, dir_rows[i].fin);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // full chain in descending order, then requests dropped, the final one too
        for (int k = 0; k < CAPACITY + 3; k++)
        begin
            v = 32'h7FFF_FFFF - k;
            send_sample(v, k == CAPACITY + 2);
            insert_sample(v, k == CAPACITY + 2);
        end
        // exactly full, ascending, final request is the last one taken
        for (int k = 0; k < CAPACITY; k++)
        begin
            v = 32'h8000_0000 + k;
            send_sample(v, k == CAPACITY - 1);
            insert_sample(v, k == CAPACITY - 1);
        end

        rand_items = 0;
        while (rand_items < 180)
        begin
            calm = (rand_items >= 135);
            if ($urandom_range(0, 11) == 0)
                run_len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            else
                run_len = $urandom_range(1, 10);
            for (int k = 0; k < run_len; k++)
            begin
                v = pick_sample();
                send_sample(v, k == run_len - 1);
                insert_sample(v, k == run_len - 1);
            end
            rand_items += run_len;
            if (!calm && $urandom_range(0, 15) == 0)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0 && sorted_due.size() == 0)
            $display("[insertion_sort_inversion_count] OK");
        else
            $display("[insertion_sort_inversion_count] ERROR");
        $finish;
    end

endmodule
